/* sv/vpd_pkg.sv */
// Package: shared types, constants and helpers for the video presence detector
`timescale 1ns / 1ps

package vpd_pkg;

  localparam int CH_MAX   = 8;
  localparam int SAMPLE_W = 8;
  localparam int SEL_W    = 4;
  localparam int WIN_W    = 16;
  localparam int THR_W    = 24;
  localparam int CHG_W    = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(100);
  localparam logic [THR_W-1:0] THRESH_RST = THR_W'(1600);

  typedef enum logic [2:0] {
    REG_WINDOW     = 3'd0,
    REG_THRESH     = 3'd1,
    REG_AUTO       = 3'd2,
    REG_MAN_VIDEO  = 3'd3,
    REG_MAN_WHITE  = 3'd4,
    REG_MAN_RED    = 3'd5,
    REG_MAN_BYPASS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic add;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic             auto_mode;
    logic [SEL_W-1:0] man_video;
    logic [SEL_W-1:0] man_white;
    logic [SEL_W-1:0] man_red;
    logic             man_bypass;
  } sel_cfg_t;

  typedef struct packed {
    logic              window_done;
    logic              mask_changed;
    logic [CH_MAX-1:0] active_set;
    logic [CHG_W-1:0]  change_total;
    logic [SEL_W-1:0]  video_select;
    logic [SEL_W-1:0]  white_audio_select;
    logic [SEL_W-1:0]  red_audio_select;
    logic              bypass_on;
  } result_t;

  // lowest set bit, numbered from 1; 0 when empty
  function automatic logic [SEL_W-1:0] lowest_active(input logic [CH_MAX-1:0] m);
    logic [SEL_W-1:0] ch;
    ch = '0;
    for (int i = CH_MAX - 1; i >= 0; i--) begin
      if (m[i]) begin
        ch = SEL_W'(i + 1);
      end
    end
    return ch;
  endfunction

endpackage

/* sv/vpd_if.sv */
// Interfaces: packet input channel and result output channel
`timescale 1ns / 1ps

interface vpd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          packet_ok;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_0;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_1;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_2;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_3;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_4;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_5;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_6;
  logic [vpd_pkg::SAMPLE_W-1:0]  sample_7;

  modport source (output valid, packet_ok, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, input ready);
  modport sink   (input valid, packet_ok, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface vpd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        window_done;
  logic                        mask_changed;
  logic [vpd_pkg::CH_MAX-1:0]  active_set;
  logic [vpd_pkg::CHG_W-1:0]   change_total;
  logic [vpd_pkg::SEL_W-1:0]   video_select;
  logic [vpd_pkg::SEL_W-1:0]   white_audio_select;
  logic [vpd_pkg::SEL_W-1:0]   red_audio_select;
  logic                        bypass_on;

  modport source (output valid, window_done, mask_changed, active_set, change_total,
                  video_select, white_audio_select, red_audio_select, bypass_on,
                  input ready);
  modport sink   (input valid, window_done, mask_changed, active_set, change_total,
                  video_select, white_audio_select, red_audio_select, bypass_on,
                  output ready);
endinterface

/* sv/vpd_lane.sv */
// Channel lane: saturating running sum and threshold compare
`timescale 1ns / 1ps

module vpd_lane #(
  parameter int SUM_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vpd_pkg::lane_ctl_t           ctl,
  input  logic [vpd_pkg::SAMPLE_W-1:0] sample,
  input  logic [vpd_pkg::THR_W-1:0]    threshold,
  output logic                         active
);
  import vpd_pkg::*;

  localparam int CMP_W = (SUM_WIDTH > THR_W) ? SUM_WIDTH : THR_W;

  logic [SUM_WIDTH-1:0] sum_r, sum_nxt, sum_sat;
  logic [SUM_WIDTH:0]   sum_ext;

  always_comb begin
    sum_ext = {1'b0, sum_r} + (SUM_WIDTH + 1)'(sample);
    sum_sat = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
    active  = CMP_W'(sum_sat) > CMP_W'(threshold);
    sum_nxt = sum_r;
    if (ctl.add) begin
      sum_nxt = ctl.clear ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

/* sv/vpd_merge.sv */
// Merge stage: window count, mask compare, change counter and switch selection
`timescale 1ns / 1ps

module vpd_merge #(
  parameter int CHANNELS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        packet_ok,
  input  logic [vpd_pkg::WIN_W-1:0]   window_len,
  input  logic [vpd_pkg::CH_MAX-1:0]  active,
  input  vpd_pkg::sel_cfg_t           sel_cfg,
  output vpd_pkg::lane_ctl_t          ctl,
  output vpd_pkg::result_t            result
);
  import vpd_pkg::*;

  localparam logic [SEL_W-1:0] CH_TOP = SEL_W'(CHANNELS);

  logic [WIN_W-1:0]  count_r, count_nxt;
  logic [CH_MAX-1:0] mask_r, mask_nxt;
  logic [CHG_W-1:0]  chg_r, chg_nxt;
  logic [WIN_W:0]    cnt_inc;
  logic              add, done, changed;
  logic [SEL_W-1:0]  ch;

  always_comb begin
    add       = accept && packet_ok;
    cnt_inc   = {1'b0, count_r} + (WIN_W + 1)'(1);
    done      = add && (cnt_inc >= {1'b0, window_len});
    changed   = done && (active != mask_r);
    count_nxt = count_r;
    if (add) begin
      count_nxt = done ? '0 : cnt_inc[WIN_W-1:0];
    end
    mask_nxt  = changed ? active : mask_r;
    chg_nxt   = changed ? chg_r + CHG_W'(1) : chg_r;
    ctl.add   = add;
    ctl.clear = done;
  end

  always_comb begin
    ch                  = lowest_active(mask_nxt);
    result.window_done  = done;
    result.mask_changed = changed;
    result.active_set   = mask_nxt;
    result.change_total = chg_nxt;
    if (sel_cfg.auto_mode) begin
      result.video_select       = ch;
      result.white_audio_select = ch;
      result.red_audio_select   = ch;
      result.bypass_on          = (ch == '0);
    end else begin
      result.video_select       = (sel_cfg.man_video > CH_TOP) ? '0 : sel_cfg.man_video;
      result.white_audio_select = (sel_cfg.man_white > CH_TOP) ? '0 : sel_cfg.man_white;
      result.red_audio_select   = (sel_cfg.man_red > CH_TOP) ? '0 : sel_cfg.man_red;
      result.bypass_on          = sel_cfg.man_bypass;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mask_r  <= '0;
      chg_r   <= '0;
    end else begin
      count_r <= count_nxt;
      mask_r  <= mask_nxt;
      chg_r   <= chg_nxt;
    end
  end

endmodule

/* sv/video_presence_detect_autoswitch.sv */
// Top level: video presence detector with automatic input switching
`timescale 1ns / 1ps

// Takes one packet item per clock cycle unless the output stalls and returns one
// result item per packet, registered in the cycle after the packet is accepted.
// CHANNELS lanes (up to eight) each keep a saturating SUM_WIDTH-bit running sum; when
// the packet count reaches window_packets the lane sums are compared against
// presence_threshold and the merge stage updates the active mask, the change counter
// and the switch selects. The output register decouples the two sides: a new packet is
// taken whenever the output register is empty or its item is being taken in the same
// cycle, so the sustained rate is one item per cycle. Channels numbered above CHANNELS
// read as inactive. Registers are written over the APB port at byte address 4*index.

module video_presence_detect_autoswitch #(
  parameter int CHANNELS  = 8,
  parameter int SUM_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vpd_in_if.sink                      in_ch,
  vpd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [vpd_pkg::DATA_W-1:0]  pwdata,
  output logic [vpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import vpd_pkg::*;

  logic [WIN_W-1:0] window_r;
  logic [THR_W-1:0] thresh_r;
  sel_cfg_t         sel_cfg_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;

  logic                 in_ready, accept;
  logic [SAMPLE_W-1:0]  samples [CH_MAX];
  logic [CH_MAX-1:0]    active;
  lane_ctl_t            ctl;
  result_t              result, res_r;
  logic                 out_valid_r;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_WINDOW:     prdata = DATA_W'(window_r);
      REG_THRESH:     prdata = DATA_W'(thresh_r);
      REG_AUTO:       prdata = DATA_W'(sel_cfg_r.auto_mode);
      REG_MAN_VIDEO:  prdata = DATA_W'(sel_cfg_r.man_video);
      REG_MAN_WHITE:  prdata = DATA_W'(sel_cfg_r.man_white);
      REG_MAN_RED:    prdata = DATA_W'(sel_cfg_r.man_red);
      REG_MAN_BYPASS: prdata = DATA_W'(sel_cfg_r.man_bypass);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r             <= WINDOW_RST;
      thresh_r             <= THRESH_RST;
      sel_cfg_r.auto_mode  <= 1'b0;
      sel_cfg_r.man_video  <= '0;
      sel_cfg_r.man_white  <= '0;
      sel_cfg_r.man_red    <= '0;
      sel_cfg_r.man_bypass <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WINDOW:     window_r             <= pwdata[WIN_W-1:0];
        REG_THRESH:     thresh_r             <= pwdata[THR_W-1:0];
        REG_AUTO:       sel_cfg_r.auto_mode  <= pwdata[0];
        REG_MAN_VIDEO:  sel_cfg_r.man_video  <= pwdata[SEL_W-1:0];
        REG_MAN_WHITE:  sel_cfg_r.man_white  <= pwdata[SEL_W-1:0];
        REG_MAN_RED:    sel_cfg_r.man_red    <= pwdata[SEL_W-1:0];
        REG_MAN_BYPASS: sel_cfg_r.man_bypass <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  assign samples[0] = in_ch.sample_0;
  assign samples[1] = in_ch.sample_1;
  assign samples[2] = in_ch.sample_2;
  assign samples[3] = in_ch.sample_3;
  assign samples[4] = in_ch.sample_4;
  assign samples[5] = in_ch.sample_5;
  assign samples[6] = in_ch.sample_6;
  assign samples[7] = in_ch.sample_7;

  for (genvar g = 0; g < CH_MAX; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      vpd_lane #(.SUM_WIDTH(SUM_WIDTH)) u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sample    (samples[g]),
        .threshold (thresh_r),
        .active    (active[g])
      );
    end else begin : g_off
      assign active[g] = 1'b0;
    end
  end

  vpd_merge #(.CHANNELS(CHANNELS)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .packet_ok  (in_ch.packet_ok),
    .window_len (window_r),
    .active     (active),
    .sel_cfg    (sel_cfg_r),
    .ctl        (ctl),
    .result     (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.window_done        = res_r.window_done;
  assign out_ch.mask_changed       = res_r.mask_changed;
  assign out_ch.active_set         = res_r.active_set;
  assign out_ch.change_total       = res_r.change_total;
  assign out_ch.video_select       = res_r.video_select;
  assign out_ch.white_audio_select = res_r.white_audio_select;
  assign out_ch.red_audio_select   = res_r.red_audio_select;
  assign out_ch.bypass_on          = res_r.bypass_on;

endmodule

/* sv/vpd_checker.sv */
// Checker: port-level assertions for the presence detector, bound to the top level
`timescale 1ns / 1ps

module vpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        window_done,
  input logic                        mask_changed,
  input logic [vpd_pkg::CH_MAX-1:0]  active_set,
  input logic [vpd_pkg::CHG_W-1:0]   change_total,
  input logic [vpd_pkg::SEL_W-1:0]   video_select
);
  import vpd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_change_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mask_changed |-> window_done)
    else $error("mask change without completed window");

  a_select_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> video_select <= SEL_W'(CH_MAX))
    else $error("video select out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(active_set) && $stable(change_total))
    else $error("stalled item changed");

endmodule

bind video_presence_detect_autoswitch vpd_checker u_vpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .window_done  (out_ch.window_done),
  .mask_changed (out_ch.mask_changed),
  .active_set   (out_ch.active_set),
  .change_total (out_ch.change_total),
  .video_select (out_ch.video_select)
);

/* tb/video_presence_detect_autoswitch_test.sv */
// Testbench: video presence detector, directed table then random packets checked by a predictor
`timescale 1ns / 1ps

module video_presence_detect_autoswitch_test;
  import vpd_pkg::*;

  localparam int SUM_W = 24;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic                             ok;
    logic [CH_MAX-1:0][SAMPLE_W-1:0]  smp;
  } packet_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   reg_addr;
    logic [31:0]  wdata;
    packet_t      pkt;
    logic         typed;
    result_t      want;
  } row_t;

  localparam packet_t NO_PKT    = '0;
  localparam result_t NO_RES    = '0;
  localparam result_t RESET_OUT = '{1'b0, 1'b0, 8'h00, 16'd0, 4'd0, 4'd0, 4'd0, 1'b1};

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  vpd_in_if  in_if ();
  vpd_out_if out_if ();

  video_presence_detect_autoswitch i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // detector state and register copies
  logic [SUM_W-1:0]  acc [CH_MAX];
  logic [WIN_W-1:0]  pkt_count;
  logic [CH_MAX-1:0] live_mask;
  logic [CHG_W-1:0]  change_count;
  logic [WIN_W-1:0]  win;
  logic [THR_W-1:0]  thresh;
  logic              auto_on;
  logic [SEL_W-1:0]  man_video;
  logic [SEL_W-1:0]  man_white;
  logic [SEL_W-1:0]  man_red;
  logic              man_bypass;

  result_t     pending_results [$];
  int          errors;
  int          hold_request;
  bit          idle_on;
  logic [CH_MAX-1:0] lit;

  row_t plan [31] = '{
    '{ROW_ITEM,  '0, '0, '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, RESET_OUT},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h0}, 1'b1, RESET_OUT},
    '{ROW_WRITE, REG_WINDOW, 32'd1, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{1'b1, 1'b0, 8'h00, 16'd0, 4'd0, 4'd0, 4'd0, 1'b1}},
    '{ROW_WRITE, REG_THRESH, 32'd0, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h0000_0000_0000_0001}, 1'b1,
      '{1'b1, 1'b1, 8'h01, 16'd1, 4'd0, 4'd0, 4'd0, 1'b1}},
    '{ROW_WRITE, REG_AUTO, 32'd1, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h0100_0000_0000_0000}, 1'b1,
      '{1'b1, 1'b1, 8'h80, 16'd2, 4'd8, 4'd8, 4'd8, 1'b0}},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h0}, 1'b1,
      '{1'b1, 1'b1, 8'h00, 16'd3, 4'd0, 4'd0, 4'd0, 1'b1}},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{1'b1, 1'b1, 8'hFF, 16'd4, 4'd1, 4'd1, 4'd1, 1'b0}},
    '{ROW_ITEM,  '0, '0, '{1'b0, 64'h5555_5555_5555_5555}, 1'b1,
      '{1'b0, 1'b0, 8'hFF, 16'd4, 4'd1, 4'd1, 4'd1, 1'b0}},
    '{ROW_WRITE, REG_THRESH, 32'h00FF_FFFF, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_WINDOW, 32'd0, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{1'b1, 1'b1, 8'h00, 16'd5, 4'd0, 4'd0, 4'd0, 1'b1}},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b1,
      '{1'b1, 1'b0, 8'h00, 16'd5, 4'd0, 4'd0, 4'd0, 1'b1}},
    '{ROW_WRITE, REG_WINDOW, 32'd3, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_THRESH, 32'd100, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h4040_4040_4040_4040}, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h4040_4040_4040_4040}, 1'b0, NO_RES},
    // window lowered mid-window
    '{ROW_WRITE, REG_WINDOW, 32'd1, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h0}, 1'b0, NO_RES},
    '{ROW_WRITE, REG_AUTO, 32'd0, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_MAN_VIDEO, 32'd8, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_MAN_WHITE, 32'd9, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_MAN_RED, 32'd15, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_MAN_BYPASS, 32'd0, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_SPARE, 32'hFFFF_FFFF, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b0, 64'h0}, 1'b1,
      '{1'b0, 1'b0, 8'hFF, 16'd6, 4'd8, 4'd0, 4'd0, 1'b0}},
    '{ROW_WRITE, REG_MAN_VIDEO, 32'hFFFF_FFF1, NO_PKT, 1'b0, NO_RES},
    '{ROW_WRITE, REG_MAN_WHITE, 32'd3, NO_PKT, 1'b0, NO_RES},
    '{ROW_ITEM,  '0, '0, '{1'b1, 64'h7F7F_7F7F_7F7F_7F7F}, 1'b0, NO_RES}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("video_presence_detect_autoswitch_test: errors");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (errors < 50) $display("%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic result_t step_detector(input packet_t p);
    result_t           r;
    logic [SUM_W:0]    widened;
    logic [WIN_W:0]    next_count;
    logic [CH_MAX-1:0] fresh;
    logic [SEL_W-1:0]  lowest;
    int                i;
    r = '0;
    if (p.ok) begin
      for (i = 0; i < CH_MAX; i++) begin
        widened = {1'b0, acc[i]} + (SUM_W + 1)'(p.smp[i]);
        acc[i] = widened[SUM_W] ? '1 : widened[SUM_W-1:0];
      end
      next_count = {1'b0, pkt_count} + 1'b1;
      if (next_count >= {1'b0, win}) begin
        r.window_done = 1'b1;
        fresh = '0;
        for (i = 0; i < CH_MAX; i++) begin
          fresh[i] = acc[i] > thresh;
          acc[i] = '0;
        end
        pkt_count = '0;
        if (fresh != live_mask) begin
          live_mask = fresh;
          r.mask_changed = 1'b1;
          change_count = change_count + 1'b1;
        end
      end else begin
        pkt_count = next_count[WIN_W-1:0];
      end
    end
    r.active_set   = live_mask;
    r.change_total = change_count;
    if (auto_on) begin
      lowest = '0;
      for (i = 0; i < CH_MAX; i++) begin
        if (lowest == 0 && live_mask[i]) lowest = SEL_W'(i + 1);
      end
      r.video_select       = lowest;
      r.white_audio_select = lowest;
      r.red_audio_select   = lowest;
      r.bypass_on          = (lowest == 0);
    end else begin
      r.video_select       = (man_video > CH_MAX) ? '0 : man_video;
      r.white_audio_select = (man_white > CH_MAX) ? '0 : man_white;
      r.red_audio_select   = (man_red > CH_MAX) ? '0 : man_red;
      r.bypass_on          = man_bypass;
    end
    return r;
  endfunction

  function automatic packet_t make_packet();
    packet_t p;
    int      i;
    for (i = 0; i < CH_MAX; i++) begin
      if ($urandom_range(15) == 0) lit[i] = ~lit[i];
      p.smp[i] = lit[i] ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127, 0));
      if ($urandom_range(9) == 0) p.smp[i] = 8'($urandom);
    end
    p.ok = ($urandom_range(9) != 0);
    return p;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch("result item with nothing expected");
      return;
    end
    want = pending_results.pop_front();
    if (got.window_done !== want.window_done)
      flag_mismatch($sformatf("window_done %0b, want %0b", got.window_done, want.window_done));
    if (got.mask_changed !== want.mask_changed)
      flag_mismatch($sformatf("mask_changed %0b, want %0b", got.mask_changed,
                              want.mask_changed));
    if (got.active_set !== want.active_set)
      flag_mismatch($sformatf("active_set %h, want %h", got.active_set, want.active_set));
    if (got.change_total !== want.change_total)
      flag_mismatch($sformatf("change_total %0d, want %0d", got.change_total,
                              want.change_total));
    if (got.video_select !== want.video_select)
      flag_mismatch($sformatf("video_select %0d, want %0d", got.video_select,
                              want.video_select));
    if (got.white_audio_select !== want.white_audio_select)
      flag_mismatch($sformatf("white_audio_select %0d, want %0d", got.white_audio_select,
                              want.white_audio_select));
    if (got.red_audio_select !== want.red_audio_select)
      flag_mismatch($sformatf("red_audio_select %0d, want %0d", got.red_audio_select,
                              want.red_audio_select));
    if (got.bypass_on !== want.bypass_on)
      flag_mismatch($sformatf("bypass_on %0b, want %0b", got.bypass_on, want.bypass_on));
  endtask

  task automatic send_packet(input packet_t p, input logic typed, input result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.packet_ok <= p.ok;
    in_if.sample_0  <= p.smp[0];
    in_if.sample_1  <= p.smp[1];
    in_if.sample_2  <= p.smp[2];
    in_if.sample_3  <= p.smp[3];
    in_if.sample_4  <= p.smp[4];
    in_if.sample_5  <= p.smp[5];
    in_if.sample_6  <= p.smp[6];
    in_if.sample_7  <= p.smp[7];
    do @(posedge clk); while (!in_if.ready);
    predicted = step_detector(p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // stop offering, let every result drain, then let the design settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] readback;
    bit          known;
    wait_idle();
    known = 1'b1;
    case (idx)
      REG_WINDOW:     begin win = data[WIN_W-1:0];      readback = 32'(win);        end
      REG_THRESH:     begin thresh = data[THR_W-1:0];   readback = 32'(thresh);     end
      REG_AUTO:       begin auto_on = data[0];          readback = 32'(auto_on);    end
      REG_MAN_VIDEO:  begin man_video = data[SEL_W-1:0]; readback = 32'(man_video); end
      REG_MAN_WHITE:  begin man_white = data[SEL_W-1:0]; readback = 32'(man_white); end
      REG_MAN_RED:    begin man_red = data[SEL_W-1:0];   readback = 32'(man_red);   end
      REG_MAN_BYPASS: begin man_bypass = data[0];       readback = 32'(man_bypass); end
      default:        begin known = 1'b0;               readback = '0;              end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (known && prdata !== readback)
      flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, readback));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : result_sink
    int      hold_left;
    result_t got;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = '{out_if.window_done, out_if.mask_changed, out_if.active_set,
                out_if.change_total, out_if.video_select, out_if.white_audio_select,
                out_if.red_audio_select, out_if.bypass_on};
        check_result(got);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 15);
      end
    end
  end

  initial begin : stimulus
    int               ph;
    int               n;
    int               count;
    logic [WIN_W-1:0] phase_win;
    logic [THR_W-1:0] phase_thr;
    errors          = 0;
    hold_request    = 0;
    idle_on         = 1'b1;
    lit             = '0;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.packet_ok = 1'b0;
    in_if.sample_0  = '0;
    in_if.sample_1  = '0;
    in_if.sample_2  = '0;
    in_if.sample_3  = '0;
    in_if.sample_4  = '0;
    in_if.sample_5  = '0;
    in_if.sample_6  = '0;
    in_if.sample_7  = '0;
    for (n = 0; n < CH_MAX; n++) acc[n] = '0;
    pkt_count    = '0;
    live_mask    = '0;
    change_count = '0;
    win          = WINDOW_RST;
    thresh       = THRESH_RST;
    auto_on      = 1'b0;
    man_video    = '0;
    man_white    = '0;
    man_red      = '0;
    man_bypass   = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].reg_addr, plan[i].wdata);
      else send_packet(plan[i].pkt, plan[i].typed, plan[i].want);
    end

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       phase_win = 16'd1;
        1:       phase_win = 16'd0;
        2:       phase_win = 16'hFFFF;
        default: phase_win = 16'($urandom_range(12, 2));
      endcase
      case (ph)
        2:       phase_thr = 24'($urandom_range(24'hFFFFFF, 0));
        3:       phase_thr = '0;
        4:       phase_thr = 24'hFFFFFF;
        default: phase_thr = 24'((phase_win == 0 ? 1 : phase_win) * $urandom_range(200, 60));
      endcase
      write_reg(REG_WINDOW, 32'(phase_win));
      write_reg(REG_THRESH, 32'(phase_thr));
      write_reg(REG_AUTO, 32'(ph % 2 == 0));
      write_reg(REG_MAN_VIDEO, $urandom_range(15, 0));
      write_reg(REG_MAN_WHITE, $urandom_range(15, 0));
      write_reg(REG_MAN_RED, $urandom_range(15, 0));
      write_reg(REG_MAN_BYPASS, $urandom_range(1, 0));
      idle_on = (ph != 5);
      count   = (ph == 2) ? 40 : 190;
      for (n = 0; n < count; n++) begin
        if (ph == 6 && n == 50) hold_request = 300;
        if (ph == 7 && n == 100) wait_idle();
        send_packet(make_packet(), 1'b0, NO_RES);
      end
    end
    idle_on = 1'b1;

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("video_presence_detect_autoswitch_test: clean");
    end else begin
      $display("video_presence_detect_autoswitch_test: errors");
    end
    $finish;
  end

endmodule
